@@ hdl/ssit_pkg.sv @@
// Package for the sorted sparse index table: request/response structs and codes.
// No dependencies.
package ssit_pkg;

   localparam int unsigned IDX_W = 31;
   localparam int unsigned VAL_W = 32;
   localparam int unsigned TOT_W = 9;

   typedef enum logic [2:0] {
      REQ_LOOKUP = 3'd0,
      REQ_SET    = 3'd1,
      REQ_UNSET  = 3'd2,
      REQ_APPEND = 3'd3,
      REQ_CLEAR  = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOT_SET  = 2'd1,
      ST_FULL     = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_code_type;

   typedef struct packed {
      logic [2:0]       req_type;
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [VAL_W-1:0]  read_value;
      logic [IDX_W-1:0]  used_index;
      logic [TOT_W-1:0]  entry_total;
      logic signed [31:0] highest_index;
   } rsp_type;

   // Entry as stored in the slot memory.
   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] val;
   } slot_type;

endpackage

@@ hdl/ssit_mem.sv @@
// Slot memory for the sorted index table: one write port, one registered read port.
// Depends on ssit_pkg.
module ssit_mem #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = 8
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ssit_pkg::slot_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output ssit_pkg::slot_type  rd_data
);
   import ssit_pkg::*;

   slot_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/sparse_sorted_index_table_top.sv @@
// Sorted sparse index table: binary search over a slot memory (ssit_mem, ssit_pkg),
// then a shift sweep for insert or remove, each moved entry read in S_SHRD and written
// in S_SHWR; an insert or remove then refreshes the cached highest index. Clear, append
// overflow and unused codes skip the search and go straight to S_DONE.
// Throughput: one transaction at a time; next request taken once the previous result
// is loaded. Reset clears count and control state; memory is not cleared.
module sparse_sorted_index_table_top #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ssit_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ssit_pkg::rsp_type rsp_data
);
   import ssit_pkg::*;

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_TOP    = 10'b0000000010,
      S_TOPW   = 10'b0000000100,
      S_SRCH   = 10'b0000001000,
      S_SRCHW  = 10'b0000010000,
      S_FINAL  = 10'b0000100000,
      S_DECIDE = 10'b0001000000,
      S_SHRD   = 10'b0010000000,
      S_SHWR   = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]    ptr_ff, ptr_in;       // shift sweep pointer
   logic [2:0]       op_ff, op_in;
   logic [IDX_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0] used_ff, used_in;
   logic [1:0]       stat_ff, stat_in;
   logic [VAL_W-1:0] rd_ff, rd_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] top_ff, top_in;       // highest index, valid when count>0
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   slot_type         wr_data, rd_data;
   logic [CW-1:0]    mid;

   ssit_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ptr_in       = ptr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      used_in      = used_ff;
      stat_in      = stat_ff;
      rd_in        = rd_ff;
      hit_in       = hit_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(ptr_ff);
      wr_data      = '{idx: key_ff, val: val_ff};
      rd_addr      = AW'(mid);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_data.req_type;
               key_in  = req_data.index;
               val_in  = req_data.value;
               used_in = req_data.index;
               stat_in = ST_OK;
               rd_in   = '0;
               hit_in  = 1'b0;
               lo_in   = '0;
               hi_in   = count_ff;
               case (req_data.req_type)
                  REQ_LOOKUP, REQ_SET, REQ_UNSET: state_in = S_SRCH;
                  REQ_APPEND: begin
                     if (count_ff == '0) begin
                        key_in  = '0;
                        state_in = S_SRCH;
                     end else if (&top_ff) begin
                        stat_in  = ST_OVERFLOW;
                        state_in = S_DONE;
                     end else begin
                        key_in   = top_ff + 1'b1;
                        state_in = S_SRCH;
                     end
                  end
                  REQ_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = AW'(mid);
               state_in = S_SRCHW;
            end else begin
               rd_addr  = AW'(lo_ff);
               state_in = S_FINAL;
            end
         end
         S_SRCHW: begin
            if (rd_data.idx < key_ff) lo_in = mid + 1'b1;
            else hi_in = mid;
            state_in = S_SRCH;
         end
         S_FINAL: begin
            // lo holds the first position with index >= key
            hit_in   = (lo_ff < count_ff) && (rd_data.idx == key_ff);
            rd_in    = rd_data.val;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            case (op_ff)
               REQ_LOOKUP: begin
                  if (!hit_ff) begin
                     stat_in = ST_NOT_SET;
                     rd_in   = '0;
                  end
                  state_in = S_DONE;
               end
               REQ_UNSET: begin
                  rd_in = '0;
                  if (!hit_ff) begin
                     stat_in  = ST_NOT_SET;
                     state_in = S_DONE;
                  end else begin
                     ptr_in   = lo_ff;   // move slot ptr+1 down to ptr
                     state_in = S_SHRD;
                  end
               end
               default: begin            // set and append
                  rd_in = '0;
                  if (hit_ff) begin
                     wr_en    = 1'b1;
                     wr_addr  = AW'(lo_ff);
                     used_in  = key_ff;
                     state_in = S_DONE;
                  end else if (count_ff >= CW'(TABLE_DEPTH)) begin
                     stat_in  = ST_FULL;
                     state_in = S_DONE;
                  end else begin
                     used_in  = key_ff;
                     ptr_in   = count_ff; // move slot ptr-1 up to ptr
                     state_in = S_SHRD;
                  end
               end
            endcase
         end
         S_SHRD: begin
            if (op_ff == REQ_UNSET) begin
               if (ptr_ff + 1'b1 >= count_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_TOP;
               end else begin
                  rd_addr  = AW'(ptr_ff + 1'b1);
                  state_in = S_SHWR;
               end
            end else begin
               if (ptr_ff == lo_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = AW'(lo_ff);
                  count_in = count_ff + 1'b1;
                  state_in = S_TOP;
               end else begin
                  rd_addr  = AW'(ptr_ff - 1'b1);
                  state_in = S_SHWR;
               end
            end
         end
         S_SHWR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(ptr_ff);
            wr_data = rd_data;
            if (op_ff == REQ_UNSET) ptr_in = ptr_ff + 1'b1;
            else ptr_in = ptr_ff - 1'b1;
            state_in = S_SHRD;
         end
         S_TOP: begin
            // refresh cached highest index after a change in count
            rd_addr  = AW'(count_ff - 1'b1);
            state_in = S_TOPW;
         end
         S_TOPW: begin
            if (count_ff != '0) top_in = rd_data.idx;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = stat_ff;
               rsp_in.read_value     = rd_ff;
               rsp_in.used_index     = used_ff;
               rsp_in.entry_total    = TOT_W'(count_ff);
               rsp_in.highest_index  = (count_ff == '0) ? '1 : {1'b0, top_ff};
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      ptr_ff  <= ptr_in;
      op_ff   <= op_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      used_ff <= used_in;
      stat_ff <= stat_in;
      rd_ff   <= rd_in;
      hit_ff  <= hit_in;
      top_ff  <= top_in;
      rsp_ff  <= rsp_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH)) else $error("count above depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (count_ff == '0 ||
      count_ff == $past(count_ff) + 1'b1 || count_ff == $past(count_ff) - 1'b1))
      else $error("count jumped");
   a_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.entry_total == '0) |-> (rsp_data.highest_index == -1))
      else $error("empty table reports a highest index");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accept while busy");

endmodule
